// ===== rtl/hps_pkg.sv =====
`default_nettype none

package hps_pkg;

  // Field widths fixed by the interface
  localparam int POWER_W    = 20;
  localparam int FLOOR_W    = 16;
  localparam int BINW_W     = 30;
  localparam int FREQ_W     = 32;
  localparam int PEAK_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Product datapath widths
  localparam int SUM_W  = POWER_W + 1;        // power plus noise floor
  localparam int AB_W   = POWER_W + SUM_W;    // first partial product
  localparam int SPLIT  = SUM_W;              // cut point of the second multiply
  localparam int LO_W   = SPLIT + SUM_W;
  localparam int HI_W   = (AB_W - SPLIT) + SUM_W;
  localparam int PROD_W = POWER_W + 2 * SUM_W;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH   = 2'd1;

  // Reset values of the configuration registers
  localparam logic [FLOOR_W-1:0] NOISE_FLOOR_RST = 16'd1;
  localparam logic [BINW_W-1:0]  BIN_WIDTH_RST   = 30'd1411200;

  typedef struct packed {
    logic [POWER_W-1:0] bin_power;
    logic               last_bin;
  } in_payload_t;

  typedef struct packed {
    logic [PEAK_W-1:0] peak_index;
    logic [FREQ_W-1:0] low_frequency;
    logic [FREQ_W-1:0] high_frequency;
  } out_payload_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_SCALE,
    ST_HOLD
  } search_state_t;

  // Which of the three harmonic bins a store read fetches
  typedef enum logic [1:0] {
    PH_FUND,
    PH_SECOND,
    PH_THIRD
  } read_phase_t;

endpackage

`default_nettype wire

// ===== rtl/hps_queue.sv =====
`default_nettype none

module hps_queue #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entry_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;

  assign empty    = (count_r == 2'd0);
  assign pop_data = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold the job data
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hps_front.sv =====
`default_nettype none

module hps_front #(
  parameter int DEPTH  = 1025,
  parameter int ADDR_W = 11,
  parameter int CNT_W  = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  hps_pkg::in_payload_t         in_payload,
  input  logic                         store_busy,
  input  logic                         q_empty,
  output logic                         push,
  output logic [ADDR_W-1:0]            push_last,
  output logic                         wr_en,
  output logic [ADDR_W-1:0]            wr_addr,
  output logic [hps_pkg::POWER_W-1:0]  wr_data
);

  import hps_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             room;

  // Hold input while the store is being searched or a search is waiting
  assign in_stall = !q_empty || store_busy;
  assign accept   = in_valid && !in_stall;
  assign room     = (cnt_r < CNT_W'(DEPTH));

  // Write each transfer into the store; drop bins beyond its depth
  assign wr_en   = accept && room;
  assign wr_addr = cnt_r[ADDR_W-1:0];
  assign wr_data = in_payload.bin_power;

  // Close the frame on the last bin and queue a search job
  assign push      = accept && in_payload.last_bin;
  assign push_last = room ? cnt_r[ADDR_W-1:0] : ADDR_W'(DEPTH - 1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_payload.last_bin) begin
        cnt_nxt = '0;
      end else if (room) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hps_search.sv =====
`default_nettype none

module hps_search #(
  parameter int DEPTH  = 1025,
  parameter int ADDR_W = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [hps_pkg::POWER_W-1:0]  wr_data,
  input  logic                         job_valid,
  input  logic [ADDR_W-1:0]            job_last,
  output logic                         job_pop,
  input  logic [hps_pkg::FLOOR_W-1:0]  noise_floor,
  input  logic [hps_pkg::BINW_W-1:0]   bin_width,
  output logic                         store_busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output hps_pkg::out_payload_t        out_payload
);

  import hps_pkg::*;

  localparam int AW2  = ADDR_W + 2;            // room for 3*i past the last bin
  localparam int SC_W = BINW_W + ADDR_W + 1;   // bin width times odd multiple

  // Spectrum store, one write and one registered read port
  logic [POWER_W-1:0] mem [DEPTH];

  search_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  last_r;
  logic [AW2-1:0]     ia_r, ib_r, ic_r;
  read_phase_t        ph_r;
  logic               more;
  logic               issue;
  logic               load_out;
  logic [ADDR_W-1:0]  rd_addr;

  logic               rd_vld_r;
  read_phase_t        rd_ph_r;
  logic [ADDR_W-1:0]  rd_idx_r;
  logic [POWER_W-1:0] rd_data_r;
  logic [SUM_W-1:0]   rd_sum;

  logic [POWER_W-1:0] a_r;
  logic [ADDR_W-1:0]  a_idx_r;
  logic [AB_W-1:0]    ab_r;
  logic [LO_W-1:0]    pl_r;
  logic [HI_W-1:0]    pm_r;
  logic               pp_vld_r;
  logic [ADDR_W-1:0]  pp_idx_r;
  logic [PROD_W-1:0]  prod;

  logic [PROD_W-1:0]  best_r;
  logic [ADDR_W-1:0]  best_idx_r;

  logic [ADDR_W:0]    odd_mult;
  logic [SC_W-1:0]    scale_r;
  logic [SC_W-1:0]    low_x, high_x, w_x, half_x;
  logic [ADDR_W+PEAK_W-1:0] peak_x;

  logic               out_valid_r;
  out_payload_t       out_payload_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (job_valid) state_nxt = ST_SEARCH;
      ST_SEARCH: if (!more) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!rd_vld_r && !pp_vld_r) state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_HOLD;
      ST_HOLD:   if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    job_pop    = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    store_busy = 1'b0;
    case (state_r)
      ST_IDLE:   job_pop = job_valid;
      ST_SEARCH: begin
        issue      = more;
        store_busy = 1'b1;
      end
      ST_DRAIN:  store_busy = 1'b1;
      ST_SCALE:  ;
      ST_HOLD:   load_out = !out_valid_r || !out_stall;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Candidate continues while its third harmonic lies inside the frame
  assign more = (ic_r <= AW2'(last_r));

  // Pick the store address for the current read phase
  always_comb begin
    case (ph_r)
      PH_FUND:   rd_addr = ia_r[ADDR_W-1:0];
      PH_SECOND: rd_addr = ib_r[ADDR_W-1:0];
      PH_THIRD:  rd_addr = ic_r[ADDR_W-1:0];
      default:   rd_addr = ia_r[ADDR_W-1:0];
    endcase
  end

  // Store write and read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Step the candidate addresses: i, 2i, 3i
  always_ff @(posedge clk) begin
    if (job_pop) begin
      last_r <= job_last;
      ia_r   <= AW2'(1);
      ib_r   <= AW2'(2);
      ic_r   <= AW2'(3);
    end else if (issue && ph_r == PH_THIRD) begin
      ia_r <= ia_r + AW2'(1);
      ib_r <= ib_r + AW2'(2);
      ic_r <= ic_r + AW2'(3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= PH_FUND;
      rd_vld_r <= 1'b0;
      rd_ph_r  <= PH_FUND;
      pp_vld_r <= 1'b0;
    end else begin
      if (job_pop) begin
        ph_r <= PH_FUND;
      end else if (issue) begin
        case (ph_r)
          PH_FUND:   ph_r <= PH_SECOND;
          PH_SECOND: ph_r <= PH_THIRD;
          PH_THIRD:  ph_r <= PH_FUND;
          default:   ph_r <= PH_FUND;
        endcase
      end
      rd_vld_r <= issue;
      rd_ph_r  <= ph_r;
      pp_vld_r <= rd_vld_r && (rd_ph_r == PH_THIRD);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx_r <= ia_r[ADDR_W-1:0];
    end
  end

  // Harmonic bin plus floor
  assign rd_sum = SUM_W'(rd_data_r) + SUM_W'(noise_floor);

  // Product pipeline: fundamental, times second, then third in two halves
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      case (rd_ph_r)
        PH_FUND: begin
          a_r     <= rd_data_r;
          a_idx_r <= rd_idx_r;
        end
        PH_SECOND: ab_r <= AB_W'(a_r) * AB_W'(rd_sum);
        PH_THIRD: begin
          pl_r     <= LO_W'(ab_r[SPLIT-1:0]) * LO_W'(rd_sum);
          pm_r     <= HI_W'(ab_r[AB_W-1:SPLIT]) * HI_W'(rd_sum);
          pp_idx_r <= a_idx_r;
        end
        default: ;
      endcase
    end
  end

  assign prod = {pm_r, {SPLIT{1'b0}}} + PROD_W'(pl_r);

  // Keep the first strict maximum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r     <= '0;
      best_idx_r <= '0;
    end else if (job_pop) begin
      best_r     <= '0;
      best_idx_r <= '0;
    end else if (pp_vld_r && prod > best_r) begin
      best_r     <= prod;
      best_idx_r <= pp_idx_r;
    end
  end

  // Scale the bin width by 2k-1 for the lower bound
  assign odd_mult = {best_idx_r, 1'b0} - (ADDR_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (state_r == ST_SCALE) begin
      scale_r <= SC_W'(bin_width) * SC_W'(odd_mult);
    end
  end

  // Frequency bounds; end bins are half wide
  assign w_x    = SC_W'(bin_width);
  assign half_x = SC_W'(bin_width >> 1);

  always_comb begin
    if (best_idx_r == '0) begin
      low_x  = '0;
      high_x = half_x;
    end else begin
      low_x = scale_r >> 1;
      if (best_idx_r == last_r) begin
        high_x = low_x + half_x;
      end else begin
        high_x = low_x + w_x;
      end
    end
  end

  assign peak_x = (ADDR_W + PEAK_W)'(best_idx_r);

  // Output register, loaded when empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_payload_r.peak_index     <= peak_x[PEAK_W-1:0];
      out_payload_r.low_frequency  <= (|low_x[SC_W-1:FREQ_W]) ? '1 : low_x[FREQ_W-1:0];
      out_payload_r.high_frequency <= (|high_x[SC_W-1:FREQ_W]) ? '1 : high_x[FREQ_W-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

endmodule

`default_nettype wire

// ===== rtl/harmonic_product_spectrum_peak_unit.sv =====
`default_nettype none

// Harmonic product spectrum peak unit.
// Input channel (in_valid / in_stall / in_payload): one power bin per transfer,
// bin 0 first; the transfer with last_bin set closes the frame and queues a
// search. Bins load at one per cycle while in_stall is low.
// Search: three reads of the store's single read port per candidate i (bins i,
// 2i, 3i), from i = 1 while 3i does not pass the last bin index. The product
// uses one 20x21 multiply and then splits the second multiply into a 21-bit
// low half and a 20-bit high half of the first product, each registered.
// While a search is queued, reads the store or drains its products, in_stall
// is high; then the next frame may load while the result waits for the output.
// Output channel (out_valid / out_stall / out_payload): one result per frame,
// held in an output register; a stalled result stays unchanged and the search
// unit waits until it has been taken.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// write only while the block is idle.
// Reset (rst_n low, synchronous) empties the frame, the job queue and the
// output, and restores noise_floor = 1 and bin_width = 1411200. The store
// contents are not cleared.

module harmonic_product_spectrum_peak_unit #(
  parameter int MAX_FRAME = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hps_pkg::in_payload_t            in_payload,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hps_pkg::out_payload_t           out_payload,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import hps_pkg::*;

  localparam int DEPTH  = MAX_FRAME / 2 + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [FLOOR_W-1:0] noise_floor_r;
  logic [BINW_W-1:0]  bin_width_r;

  logic               store_busy;
  logic               q_empty;
  logic               push;
  logic               pop;
  logic [ADDR_W-1:0]  push_last;
  logic [ADDR_W-1:0]  job_last;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [POWER_W-1:0] wr_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_floor_r <= NOISE_FLOOR_RST;
      bin_width_r   <= BIN_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NOISE_FLOOR: noise_floor_r <= cfg_data[FLOOR_W-1:0];
        REG_BIN_WIDTH:   bin_width_r   <= cfg_data[BINW_W-1:0];
        default:         ;
      endcase
    end
  end

  hps_front #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .store_busy (store_busy),
    .q_empty    (q_empty),
    .push       (push),
    .push_last  (push_last),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  hps_queue #(
    .W (ADDR_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_last),
    .pop       (pop),
    .empty     (q_empty),
    .pop_data  (job_last)
  );

  hps_search #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .job_valid   (!q_empty),
    .job_last    (job_last),
    .job_pop     (pop),
    .noise_floor (noise_floor_r),
    .bin_width   (bin_width_r),
    .store_busy  (store_busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire

// ===== rtl/hps_checker.sv =====
`default_nettype none

module hps_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_stall,
  input wire hps_pkg::in_payload_t      in_payload,
  input wire                            out_valid,
  input wire                            out_stall,
  input wire hps_pkg::out_payload_t     out_payload
);

  logic       frame_end;
  logic       out_xfer;
  logic [2:0] pending_r, pending_nxt;

  assign frame_end = in_valid && !in_stall && in_payload.last_bin;
  assign out_xfer  = out_valid && !out_stall;

  // Count frames closed but not yet answered
  always_comb begin
    pending_nxt = pending_r;
    if (frame_end && !out_xfer) begin
      pending_nxt = pending_r + 3'd1;
    end else if (out_xfer && !frame_end) begin
      pending_nxt = pending_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 3'd0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");

  // Every result answers a closed frame, and few frames are in flight
  a_out_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending_r != 3'd0) && (pending_r <= 3'd3))
    else $error("result without a closed frame");

  // Closing a frame holds the input while its search is queued
  a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> in_stall)
    else $error("input taken while a search is queued");

  // No peak means the lower bound is zero
  a_zero_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_payload.peak_index == '0) |-> (out_payload.low_frequency == '0))
    else $error("lower bound of bin zero not zero");

  // Upper bound never below lower bound
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload.high_frequency >= out_payload.low_frequency))
    else $error("frequency bounds out of order");

endmodule

bind harmonic_product_spectrum_peak_unit hps_checker u_checker (.*);

`default_nettype wire
